@@ src/fbc_pkg.sv @@
// fbc_pkg: widths, payload types, register indexes and pipeline control types
// for the frustum box cull block. Has no dependencies; every file but fbc_check imports it.
`default_nettype none

package fbc_pkg;

    localparam int PLANE_COUNT = 4;
    localparam int MAX_PLANES  = 4;

    localparam int COORD_W     = 32;
    localparam int NORM_W      = 16;
    localparam int NORM_PACK_W = 3 * NORM_W;
    localparam int DIST_W      = 32;
    localparam int PROD_W      = NORM_W + COORD_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int FRAC_SHIFT  = 14;
    localparam int DOT_W       = SUM_W - FRAC_SHIFT;

    localparam int REG_COUNT   = 2 * MAX_PLANES;
    localparam int CFG_IDX_W   = $clog2(REG_COUNT);
    localparam int CFG_DATA_W  = NORM_PACK_W;

    localparam int NUM_STAGES  = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PLANE0_NORMAL   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE0_DISTANCE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE1_NORMAL   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE1_DISTANCE = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE2_NORMAL   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE2_DISTANCE = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE3_NORMAL   = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE3_DISTANCE = CFG_IDX_W'(7);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    typedef struct packed {
        logic [NORM_PACK_W-1:0]   normal;
        logic signed [DIST_W-1:0] distance;
    } plane_t;

    // load[k] lets stage k take its next value
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

endpackage

`default_nettype wire

@@ src/fbc_ifs.sv @@
// fbc_box_if and fbc_flag_if: valid/ready channels carrying one box and one
// cull flag. Depends on fbc_pkg.
`default_nettype none

interface fbc_box_if;
    import fbc_pkg::*;

    logic   valid;
    logic   ready;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

interface fbc_flag_if;
    logic valid;
    logic ready;
    logic outside;

    modport source (output valid, outside, input ready);
    modport sink (input valid, outside, output ready);
endinterface

`default_nettype wire

@@ src/frustum_box_cull.sv @@
// frustum_box_cull: top level of the box-against-frustum cull pipeline.
// Depends on fbc_pkg, fbc_ifs, fbc_cfg_regs, fbc_pipe_ctl and fbc_plane.
//
// Usage:
//   box    : sink channel, one axis-aligned box per beat (min and max corners,
//            signed with 8 fractional bits).
//   result : source channel, one beat per box carrying outside, set when the
//            box lies wholly on the negative side of some plane.
//   cfg_*  : write-only register port for the four plane normals (packed
//            x/y/z Q1.14) and distances; write only while no box is in flight.
// Path: an accepted box passes the product, sum and compare/output registers
//   in that order before result.valid rises.
// Throughput: one box per cycle unless result stalls, set by the three-stage
//   multiply/add/compare pipeline with a multiplier per axis and plane.
// Reset: clears the plane registers to zero and empties the pipeline; no
//   clearing pass, box.ready is high as soon as reset is released.
// Stall: a stage holds its beat while the next stage cannot load; empty stages
//   still fill, so box.ready is low only if all are full and result is stalled.
`default_nettype none

module frustum_box_cull (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    fbc_box_if.sink                             box,
    fbc_flag_if.source                          result,
    input  wire logic                           cfg_we,
    input  wire logic [fbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fbc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fbc_pkg::*;

    plane_t [MAX_PLANES-1:0]  planes;
    box_t                     box_in;
    pipe_ctl_t                ctl;
    logic [PLANE_COUNT-1:0]   below;
    logic                     outside_next;
    logic                     outside_reg;
    logic                     in_ready;
    logic                     out_valid;

    fbc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    fbc_pipe_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (box.valid),
        .out_ready (result.ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .ctl       (ctl)
    );

    assign box_in.min_x = box.box_min_x;
    assign box_in.min_y = box.box_min_y;
    assign box_in.min_z = box.box_min_z;
    assign box_in.max_x = box.box_max_x;
    assign box_in.max_y = box.box_max_y;
    assign box_in.max_z = box.box_max_z;

    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_plane
        fbc_plane u_plane (
            .clk   (clk),
            .plane (planes[p]),
            .box   (box_in),
            .ctl   (ctl),
            .below (below[p])
        );
    end

    assign outside_next = |below;

    always_ff @(posedge clk)
    begin
        if (ctl.load[NUM_STAGES-1])
        begin
            outside_reg <= outside_next;
        end
    end

    assign box.ready      = in_ready;
    assign result.valid   = out_valid;
    assign result.outside = outside_reg;

endmodule

`default_nettype wire

@@ src/fbc_cfg_regs.sv @@
// fbc_cfg_regs: plane normal and distance registers behind the write port.
// Depends on fbc_pkg.
`default_nettype none

module fbc_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [fbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fbc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output fbc_pkg::plane_t [fbc_pkg::MAX_PLANES-1:0] planes
);
    import fbc_pkg::*;

    plane_t [MAX_PLANES-1:0] planes_reg;
    plane_t [MAX_PLANES-1:0] planes_next;

    always_comb
    begin
        planes_next = planes_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PLANE0_NORMAL:   planes_next[0].normal   = cfg_data[NORM_PACK_W-1:0];
                REG_PLANE0_DISTANCE: planes_next[0].distance = cfg_data[DIST_W-1:0];
                REG_PLANE1_NORMAL:   planes_next[1].normal   = cfg_data[NORM_PACK_W-1:0];
                REG_PLANE1_DISTANCE: planes_next[1].distance = cfg_data[DIST_W-1:0];
                REG_PLANE2_NORMAL:   planes_next[2].normal   = cfg_data[NORM_PACK_W-1:0];
                REG_PLANE2_DISTANCE: planes_next[2].distance = cfg_data[DIST_W-1:0];
                REG_PLANE3_NORMAL:   planes_next[3].normal   = cfg_data[NORM_PACK_W-1:0];
                REG_PLANE3_DISTANCE: planes_next[3].distance = cfg_data[DIST_W-1:0];
                default:             planes_next = planes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planes_reg <= '0;
        end
        else
        begin
            planes_reg <= planes_next;
        end
    end

    assign planes = planes_reg;

endmodule

`default_nettype wire

@@ src/fbc_pipe_ctl.sv @@
// fbc_pipe_ctl: valid bits and per-stage ready chain of the cull pipeline;
// a stage loads when it is empty or its content moves on. Depends on fbc_pkg.
`default_nettype none

module fbc_pipe_ctl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           out_ready,
    output logic                in_ready,
    output logic                out_valid,
    output fbc_pkg::pipe_ctl_t  ctl
);
    import fbc_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_ready;

    always_comb
    begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = stage_ready[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load  = stage_ready;
    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

`default_nettype wire

@@ src/fbc_plane.sv @@
// fbc_plane: p-vertex test of one box against one plane; products in the
// first stage, their sum in the second, compare feeds the third. Depends on fbc_pkg.
`default_nettype none

module fbc_plane (
    input  wire logic                clk,
    input  wire fbc_pkg::plane_t     plane,
    input  wire fbc_pkg::box_t       box,
    input  wire fbc_pkg::pipe_ctl_t  ctl,
    output logic                     below
);
    import fbc_pkg::*;

    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    coord_t                   cx;
    coord_t                   cy;
    coord_t                   cz;

    logic signed [PROD_W-1:0] prod_x_next;
    logic signed [PROD_W-1:0] prod_y_next;
    logic signed [PROD_W-1:0] prod_z_next;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_z_reg;

    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DOT_W-1:0]  dot;
    logic signed [DOT_W-1:0]  dist_ext;

    assign nx = plane.normal[NORM_W-1:0];
    assign ny = plane.normal[2*NORM_W-1:NORM_W];
    assign nz = plane.normal[3*NORM_W-1:2*NORM_W];

    // corner farthest along the normal: max where the component is non-negative
    assign cx = nx[NORM_W-1] ? box.min_x : box.max_x;
    assign cy = ny[NORM_W-1] ? box.min_y : box.max_y;
    assign cz = nz[NORM_W-1] ? box.min_z : box.max_z;

    assign prod_x_next = PROD_W'(nx) * PROD_W'(cx);
    assign prod_y_next = PROD_W'(ny) * PROD_W'(cy);
    assign prod_z_next = PROD_W'(nz) * PROD_W'(cz);

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
        end
    end

    assign sum_next = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg) + SUM_W'(prod_z_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            sum_reg <= sum_next;
        end
    end

    // arithmetic shift by dropping low bits rounds toward minus infinity
    assign dot      = sum_reg[SUM_W-1:FRAC_SHIFT];
    assign dist_ext = DOT_W'(plane.distance);
    assign below    = dot < dist_ext;

endmodule

`default_nettype wire

@@ src/fbc_check.sv @@
// fbc_check: port-level assertions for frustum_box_cull, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module fbc_check (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic box_valid,
    input wire logic box_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic outside
);

    // a result beat waiting on the receiver stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // and its flag holds
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(outside))
        else $error("result flag changed while stalled");

    // an accepted box is followed by result.valid going high
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && box_ready |-> ##3 out_valid)
        else $error("accepted box did not reach result in time");

    // an empty output stage means the whole pipe can take a beat
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> box_ready)
        else $error("input stalled with empty output stage");

endmodule

bind frustum_box_cull fbc_check u_fbc_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .box_valid (box.valid),
    .box_ready (box.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .outside   (result.outside)
);

`default_nettype wire
